// ----- design/tcce_pkg.sv -----
`default_nettype none

package tcce_pkg;

	// Field widths fixed by the item format
	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int COL_W  = 4;
	localparam int IDX_W  = 11;
	localparam int LOC_W  = 11;
	localparam int CELL_W = 16;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Control characters
	localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

	localparam int TAB_STOP = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FILL,
		ST_RDIV,
		ST_RADDR,
		ST_RDATA
	} state_t;

	// Commands from the sequencer to the cell store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic rd_in_range;
		logic row_set;
		logic row_inval;
		logic clr_all;
	} store_ctl_t;

endpackage

`default_nettype wire

// ----- design/tcce_store.sv -----
`default_nettype none

module tcce_store #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire tcce_pkg::store_ctl_t                 ctl,
	input  wire logic [$clog2(COLUMNS*ROWS)-1:0]      wr_addr,
	input  wire logic [tcce_pkg::CELL_W-1:0]          wr_data,
	input  wire logic [$clog2(COLUMNS*ROWS)-1:0]      rd_addr,
	input  wire logic [$clog2(ROWS)-1:0]              rd_row,
	input  wire logic [$clog2(ROWS)-1:0]              cur_row,
	input  wire logic [$clog2(ROWS)-1:0]              inval_row,
	output logic                                      cur_row_valid,
	output logic [tcce_pkg::CELL_W-1:0]               rd_data
);
	import tcce_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;
	logic              rd_ok_q;
	logic [ROWS-1:0]   row_valid_q;

	// Cell memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_addr];
			rd_ok_q <= ctl.rd_in_range & row_valid_q[rd_row];
		end
	end

	// Row flags: a row not marked valid reads as blank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (ctl.clr_all) begin
			row_valid_q <= '0;
		end else begin
			if (ctl.row_set) begin
				row_valid_q[cur_row] <= 1'b1;
			end
			if (ctl.row_inval) begin
				row_valid_q[inval_row] <= 1'b0;
			end
		end
	end

	assign cur_row_valid = row_valid_q[cur_row];
	assign rd_data       = rd_ok_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ----- design/text_console_cursor_engine_unit.sv -----
// Put: the first write into a blank row first zeroes that row in the cell memory.
//   Put, clear and the unused op give their result from the execute state.
// Read: reciprocal split of the index, address build, memory read.
// One item in flight; the next is taken the cycle after its result enters the output register.
// Scroll rotates a row base and drops one row flag; no copying through the memory.
// Reset: cursor home, all row flags cleared so every cell reads blank; no clearing pass.
`default_nettype none

module text_console_cursor_engine_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [tcce_pkg::OP_W-1:0]    op,
	input  wire logic [tcce_pkg::CHAR_W-1:0]  char_code,
	input  wire logic [tcce_pkg::COL_W-1:0]   fg_colour,
	input  wire logic [tcce_pkg::COL_W-1:0]   bg_colour,
	input  wire logic [tcce_pkg::IDX_W-1:0]   cell_index,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [tcce_pkg::LOC_W-1:0]        cursor_location,
	output logic [tcce_pkg::CELL_W-1:0]       cell_data
);
	import tcce_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int RECIP = (1 << IDX_W) / COLUMNS;
	localparam int MW    = $clog2(RECIP + 1);

	state_t state_q, state_n;

	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] code_q;
	logic [COL_W-1:0]  fg_q, bg_q;
	logic [IDX_W-1:0]  idx_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q, base_q, prow_q;
	logic [AW-1:0] prow_base_q, loc_q;
	logic [CW-1:0] fill_cnt_q;

	logic [IDX_W+MW-1:0] prod_s1;
	logic                in_range_s1;
	logic [MW-1:0]       quot_s2;
	logic [CW-1:0]       rem_s2;
	logic                in_range_s2;

	logic              out_valid_q;
	logic [LOC_W-1:0]  cursor_location_q;
	logic [CELL_W-1:0] cell_data_q;

	// Put decode
	logic [CW:0]       col_x, tab_col, inc_col;
	logic [CW-1:0]     col_n, wcol;
	logic [CHAR_W-1:0] wcode;
	logic              wr_need, nl, scroll;
	logic [AW-1:0]     row_start, loc_n;
	logic [RW-1:0]     prow_n, base_n;
	logic [AW-1:0]     prow_base_n;

	// Read path
	logic [MW-1:0]    quot_est;
	logic [IDX_W-1:0] rem_w;
	logic [RW:0]      rsum;
	logic [RW-1:0]    rphys;
	logic [AW-1:0]    rd_addr;

	// Sequencer outputs
	logic             out_free, out_load, cur_upd, cur_clr;
	logic [LOC_W-1:0] out_loc;
	logic [CELL_W-1:0] out_data;
	store_ctl_t       ctl;
	logic [AW-1:0]    wr_addr;
	logic [CELL_W-1:0] wr_data;
	logic             cur_row_valid;
	logic [CELL_W-1:0] rd_data;

	tcce_store #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_addr       (rd_addr),
		.rd_row        (rphys),
		.cur_row       (prow_q),
		.inval_row     (base_q),
		.cur_row_valid (cur_row_valid),
		.rd_data       (rd_data)
	);

	// Cursor movement for a put
	always_comb begin
		col_x   = {1'b0, col_q};
		tab_col = (col_x | (CW+1)'(TAB_STOP - 1)) + (CW+1)'(1);
		inc_col = col_x + (CW+1)'(1);
		wr_need = 1'b0;
		nl      = 1'b0;
		col_n   = col_q;
		wcol    = col_q;
		wcode   = code_q;
		case (code_q)
			CH_NL: begin
				nl    = 1'b1;
				col_n = '0;
			end
			CH_CR: begin
				col_n = '0;
			end
			CH_BS: begin
				if (col_q != '0) begin
					col_n = col_q - CW'(1);
				end
				wcol    = col_n;
				wcode   = '0;
				wr_need = 1'b1;
			end
			CH_TAB: begin
				if (tab_col >= (CW+1)'(COLUMNS)) begin
					nl    = 1'b1;
					col_n = '0;
				end else begin
					col_n = tab_col[CW-1:0];
				end
			end
			default: begin
				wr_need = 1'b1;
				if (inc_col >= (CW+1)'(COLUMNS)) begin
					nl    = 1'b1;
					col_n = '0;
				end else begin
					col_n = inc_col[CW-1:0];
				end
			end
		endcase
		scroll    = nl && (row_q == RW'(ROWS - 2));
		row_start = loc_q - AW'(col_q);
		loc_n     = row_start + AW'(col_n) + ((nl && !scroll) ? AW'(COLUMNS) : '0);
		if (prow_q == RW'(ROWS - 1)) begin
			prow_n      = '0;
			prow_base_n = '0;
		end else begin
			prow_n      = prow_q + RW'(1);
			prow_base_n = prow_base_q + AW'(COLUMNS);
		end
		base_n = (base_q == RW'(ROWS - 1)) ? '0 : base_q + RW'(1);
	end

	// Index split: quotient estimate is low by at most one
	always_comb begin
		quot_est = prod_s1[IDX_W +: MW];
		rem_w    = idx_q - IDX_W'(quot_est * COLUMNS);
		rsum     = (RW+1)'(quot_s2) + {1'b0, base_q};
		rphys    = (rsum >= (RW+1)'(ROWS)) ? RW'(rsum - (RW+1)'(ROWS)) : RW'(rsum);
		rd_addr  = AW'(rphys * COLUMNS) + AW'(rem_s2);
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Sequencer
	always_comb begin
		state_n  = state_q;
		out_load = 1'b0;
		out_loc  = LOC_W'(loc_q);
		out_data = '0;
		cur_upd  = 1'b0;
		cur_clr  = 1'b0;
		ctl      = '0;
		wr_addr  = prow_base_q + AW'(wcol);
		wr_data  = {bg_q, fg_q, wcode};
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_PUT: begin
						if (wr_need && !cur_row_valid) begin
							state_n = ST_FILL;
						end else if (out_free) begin
							ctl.wr_en     = wr_need;
							ctl.row_inval = scroll;
							cur_upd       = 1'b1;
							out_load      = 1'b1;
							out_loc       = LOC_W'(loc_n);
							state_n       = ST_IDLE;
						end
					end
					OP_READ: begin
						state_n = ST_RDIV;
					end
					OP_CLEAR: begin
						if (out_free) begin
							ctl.clr_all = 1'b1;
							cur_clr     = 1'b1;
							out_load    = 1'b1;
							out_loc     = '0;
							state_n     = ST_IDLE;
						end
					end
					default: begin
						if (out_free) begin
							out_load = 1'b1;
							state_n  = ST_IDLE;
						end
					end
				endcase
			end
			ST_FILL: begin
				ctl.wr_en = 1'b1;
				wr_addr   = prow_base_q + AW'(fill_cnt_q);
				wr_data   = '0;
				if (fill_cnt_q == CW'(COLUMNS - 1)) begin
					ctl.row_set = 1'b1;
					state_n     = ST_EXEC;
				end
			end
			ST_RDIV: begin
				state_n = ST_RADDR;
			end
			ST_RADDR: begin
				ctl.rd_en       = 1'b1;
				ctl.rd_in_range = in_range_s2;
				state_n         = ST_RDATA;
			end
			ST_RDATA: begin
				if (out_free) begin
					out_load = 1'b1;
					out_data = rd_data;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Item capture and read-path stages
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q   <= op;
			code_q <= char_code;
			fg_q   <= fg_colour;
			bg_q   <= bg_colour;
			idx_q  <= cell_index;
		end
		prod_s1     <= (IDX_W+MW)'(idx_q * RECIP);
		in_range_s1 <= (int'(idx_q) < CELLS);
		if (state_q == ST_RDIV) begin
			in_range_s2 <= in_range_s1;
			if (rem_w >= IDX_W'(COLUMNS)) begin
				quot_s2 <= quot_est + MW'(1);
				rem_s2  <= CW'(rem_w - IDX_W'(COLUMNS));
			end else begin
				quot_s2 <= quot_est;
				rem_s2  <= CW'(rem_w);
			end
		end
	end

	// Cursor, row rotation and fill counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			base_q      <= '0;
			prow_q      <= '0;
			prow_base_q <= '0;
			loc_q       <= '0;
			fill_cnt_q  <= '0;
		end else begin
			if (state_q == ST_FILL) begin
				fill_cnt_q <= fill_cnt_q + CW'(1);
			end else begin
				fill_cnt_q <= '0;
			end
			if (cur_upd) begin
				col_q <= col_n;
				loc_q <= loc_n;
				if (nl && !scroll) begin
					row_q <= row_q + RW'(1);
				end
				if (nl) begin
					prow_q      <= prow_n;
					prow_base_q <= prow_base_n;
				end
				if (scroll) begin
					base_q <= base_n;
				end
			end else if (cur_clr) begin
				col_q       <= '0;
				row_q       <= '0;
				base_q      <= '0;
				prow_q      <= '0;
				prow_base_q <= '0;
				loc_q       <= '0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cursor_location_q <= out_loc;
			cell_data_q       <= out_data;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_location = cursor_location_q;
	assign cell_data       = cell_data_q;

`ifndef SYNTH
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(row_q) <= ROWS - 2 && int'(col_q) < COLUMNS)
		else $error("cursor outside the active rows");

	a_loc_track: assert property (@(posedge clk) disable iff (!arst_n)
		int'(loc_q) == int'(row_q) * COLUMNS + int'(col_q))
		else $error("linear location out of step with row and column");

	a_prow_base: assert property (@(posedge clk) disable iff (!arst_n)
		int'(prow_base_q) == int'(prow_q) * COLUMNS)
		else $error("physical row base address mismatch");

	a_prow_map: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(row_q) + int'(base_q) == int'(prow_q)) ||
		(int'(row_q) + int'(base_q) == int'(prow_q) + ROWS))
		else $error("physical row does not match row plus rotation");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none

module tb_top;
	import tcce_pkg::*;

	localparam int COLS        = 80;
	localparam int ROWS        = 25;
	localparam int CELLS       = COLS * ROWS;
	localparam int PHASE_ITEMS = 445;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 120;
	localparam int CYCLE_LIMIT = 600000;

	// Op code 3 is not decoded by the block
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;

	// Mirror of the text store and cursor; predicts each result in order
	class console_mirror;
		typedef struct {
			logic [LOC_W-1:0]  loc;
			logic [CELL_W-1:0] data;
		} cursor_cell_t;

		bit [CELL_W-1:0] screen [CELLS];
		int              col;
		int              row;
		cursor_cell_t    expected_cursor_cells [$];
		int              errors;
		int              checked;
		int              reads;
		int              scrolls;
		int              clears;

		function new();
			wipe();
			errors  = 0;
			checked = 0;
			reads   = 0;
			scrolls = 0;
			clears  = 0;
		endfunction

		function void wipe();
			foreach (screen[i])
				screen[i] = '0;
			col = 0;
			row = 0;
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $time, msg);
			errors++;
		endtask

		function void put_char(logic [CHAR_W-1:0] ch, logic [COL_W-1:0] fg,
				logic [COL_W-1:0] bg);
			case (ch)
			CH_NL: begin
				col = 0;
				row++;
			end
			CH_CR: col = 0;
			CH_BS: begin
				if (col != 0)
					col--;
				screen[row * COLS + col] = {bg, fg, 8'h00};
			end
			CH_TAB: begin
				col += TAB_STOP - (col % TAB_STOP);
				if (col >= COLS) begin
					col = 0;
					row++;
				end
			end
			default: begin
				screen[row * COLS + col] = {bg, fg, ch};
				col++;
				if (col >= COLS) begin
					col = 0;
					row++;
				end
			end
			endcase
			// bottom row reached: shift everything up one row, blank the last
			if (row >= ROWS - 1) begin
				for (int i = 0; i < CELLS - COLS; i++)
					screen[i] = screen[i + COLS];
				for (int i = CELLS - COLS; i < CELLS; i++)
					screen[i] = '0;
				row = ROWS - 2;
				scrolls++;
			end
		endfunction

		// Work out the result of one accepted input transfer
		function void note_item(logic [OP_W-1:0] op_i, logic [CHAR_W-1:0] ch,
				logic [COL_W-1:0] fg, logic [COL_W-1:0] bg, logic [IDX_W-1:0] idx);
			cursor_cell_t res;
			res.data = '0;
			case (op_i)
			OP_PUT: put_char(ch, fg, bg);
			OP_READ: begin
				reads++;
				if (idx < CELLS)
					res.data = screen[idx];
			end
			OP_CLEAR: begin
				wipe();
				clears++;
			end
			default: ;
			endcase
			res.loc = LOC_W'(row * COLS + col);
			expected_cursor_cells.push_back(res);
		endfunction

		task check_result(logic [LOC_W-1:0] loc, logic [CELL_W-1:0] data);
			cursor_cell_t want;
			checked++;
			if (expected_cursor_cells.size() == 0) begin
				report($sformatf("result loc=%0d data=%h with none expected", loc, data));
			end else begin
				want = expected_cursor_cells.pop_front();
				if (loc !== want.loc)
					report($sformatf("cursor_location %0d, expected %0d", loc, want.loc));
				if (data !== want.data)
					report($sformatf("cell_data %h, expected %h", data, want.data));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     op          = OP_PUT;
	logic [CHAR_W-1:0]   char_code   = '0;
	logic [COL_W-1:0]    fg_colour   = '0;
	logic [COL_W-1:0]    bg_colour   = '0;
	logic [IDX_W-1:0]    cell_index  = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic [LOC_W-1:0]    cursor_location;
	logic [CELL_W-1:0]   cell_data;

	logic                hold_off    = 1'b0;
	int                  tx_idle_pct = 0;
	int                  rx_idle_pct = 0;
	int                  phase_no    = -1;
	int                  sent        = 0;
	int                  cycle_count = 0;

	console_mirror mirror = new();

	text_console_cursor_engine_unit #(
		.COLUMNS(COLS),
		.ROWS   (ROWS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.char_code      (char_code),
		.fg_colour      (fg_colour),
		.bg_colour      (bg_colour),
		.cell_index     (cell_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cursor_location(cursor_location),
		.cell_data      (cell_data)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** text_console_cursor_engine_unit: FAILED **");
			$finish;
		end
	end

	// Receiver: random stall, forced high during the hold-off
	always @(posedge clk)
		out_stall <= hold_off || ($urandom_range(99) < rx_idle_pct);

	// Long hold-off in the last phase so the block backs up onto its input
	initial begin
		wait (phase_no == 2);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Output monitor: stall and valid are stable at the falling edge,
	// so a transfer at the next rising edge is known here
	always @(negedge clk)
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			mirror.check_result(cursor_location, cell_data);

	// One input transfer, with a random gap in front of it
	task send_item(logic [OP_W-1:0] o, logic [CHAR_W-1:0] c, logic [COL_W-1:0] f,
			logic [COL_W-1:0] b, logic [IDX_W-1:0] x);
		bit taken;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		char_code  <= c;
		fg_colour  <= f;
		bg_colour  <= b;
		cell_index <= x;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		mirror.note_item(o, c, f, b, x);
		sent++;
	endtask

	// Mostly text with control characters, some reads near the cursor, rare no-ops and clears
	task send_random();
		int               pick;
		int               base;
		logic [CHAR_W-1:0] c;
		logic [IDX_W-1:0]  x;
		logic [OP_W-1:0]   o;
		pick = $urandom_range(999);
		x    = IDX_W'($urandom_range(2047));
		o    = OP_PUT;
		if ($urandom_range(4) == 0)
			c = CHAR_W'($urandom_range(255));
		else
			c = CHAR_W'($urandom_range(32, 126));
		if (pick >= 700 && pick < 740)
			c = CH_NL;
		else if (pick >= 740 && pick < 800)
			c = CH_TAB;
		else if (pick >= 800 && pick < 840)
			c = CH_BS;
		else if (pick >= 840 && pick < 860)
			c = CH_CR;
		else if (pick >= 860 && pick < 960) begin
			o = OP_READ;
			case ($urandom_range(9))
			0, 1, 2, 3: begin
				base = mirror.row * COLS + mirror.col - $urandom_range(240);
				x    = IDX_W'(base < 0 ? 0 : base);
			end
			4, 5, 6, 7, 8: x = IDX_W'($urandom_range(CELLS - 1));
			default: x = IDX_W'($urandom_range(2047, CELLS));
			endcase
		end else if (pick >= 960 && pick < 975)
			o = OP_NOP;
		else if (pick >= 975 && pick < 977)
			o = OP_CLEAR;
		send_item(o, c, COL_W'($urandom_range(15)), COL_W'($urandom_range(15)), x);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		phase_no    = 0;
		tx_idle_pct = 24;
		rx_idle_pct = 45;

		// Directed: field extremes, each control character, edge reads
		send_item(OP_PUT,   8'h41,  4'h0, 4'h0, 11'd0);
		send_item(OP_PUT,   8'hFF,  4'hF, 4'hF, 11'h7FF);
		send_item(OP_PUT,   8'h00,  4'h5, 4'hA, 11'd0);
		send_item(OP_READ,  8'h00,  4'h0, 4'h0, 11'd0);
		send_item(OP_READ,  8'hFF,  4'hF, 4'hF, 11'd1);
		send_item(OP_READ,  8'h00,  4'h0, 4'h0, 11'd2);
		send_item(OP_PUT,   CH_BS,  4'h7, 4'h3, 11'd0);
		send_item(OP_READ,  8'h00,  4'h0, 4'h0, 11'd2);
		send_item(OP_PUT,   CH_TAB, 4'h1, 4'h2, 11'd0);
		send_item(OP_PUT,   8'h7E,  4'hC, 4'h9, 11'd0);
		send_item(OP_PUT,   CH_CR,  4'h0, 4'h0, 11'd0);
		send_item(OP_PUT,   CH_BS,  4'hE, 4'h6, 11'd0);
		send_item(OP_READ,  8'h00,  4'h0, 4'h0, 11'd0);
		send_item(OP_PUT,   CH_NL,  4'h0, 4'h0, 11'd0);
		send_item(OP_READ,  8'h00,  4'h0, 4'h0, 11'd1999);
		send_item(OP_READ,  8'h00,  4'h0, 4'h0, 11'd2000);
		send_item(OP_READ,  8'hFF,  4'hF, 4'hF, 11'd2047);
		send_item(OP_NOP,   8'hFF,  4'hF, 4'hF, 11'h7FF);
		send_item(OP_NOP,   8'h00,  4'h0, 4'h0, 11'd0);
		send_item(OP_CLEAR, 8'h41,  4'h3, 4'h4, 11'd5);
		send_item(OP_READ,  8'h00,  4'h0, 4'h0, 11'd0);
		send_item(OP_PUT,   CH_TAB, 4'h0, 4'h0, 11'd0);
		send_item(OP_PUT,   8'h5A,  4'h8, 4'h8, 11'd0);

		// Random phases: receiver-heavy stalling, sender-heavy idling, then none
		for (int p = 0; p < 3; p++) begin
			phase_no    = p;
			tx_idle_pct = (p == 0) ? 24 : (p == 1) ? 45 : 0;
			rx_idle_pct = (p == 0) ? 45 : (p == 1) ? 24 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random();
		end
		in_valid <= 1'b0;

		// Drain, then allow for a late stray result
		while (mirror.expected_cursor_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d transfers in, %0d results checked, %0d mismatches", sent,
			mirror.checked, mirror.errors);
		$display("covered %0d reads, %0d scrolls, %0d store clears", mirror.reads,
			mirror.scrolls, mirror.clears);
		if (mirror.errors == 0)
			$display("** text_console_cursor_engine_unit: PASSED **");
		else
			$display("** text_console_cursor_engine_unit: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
